@@ sv/atp_pkg.sv @@
// Shared types and constants for the ANSI truecolor text parser.
// Used by atp_core, atp_queue and the top level; depends on nothing.
package atp_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_CSI
   } mode_type;

   localparam logic [7:0] CHAR_ESC      = 8'h1B;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_ASCII_END = 8'h80;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_SGR      = 8'h6D;
   localparam logic [7:0] CHAR_RESET_MODE = 8'h6C;
   localparam logic [7:0] CHAR_SET_MODE = 8'h68;

   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   localparam logic [9:0] SGR_RESET = 10'd0;
   localparam logic [9:0] SGR_RGB   = 10'd2;
   localparam logic [9:0] SGR_FORE  = 10'd38;
   localparam logic [9:0] SGR_BACK  = 10'd48;
   localparam logic [9:0] NUM_MAX   = 10'd999;
   localparam logic [9:0] COMP_MAX  = 10'd255;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   typedef struct packed {
      logic [7:0] fore_red;
      logic [7:0] fore_green;
      logic [7:0] fore_blue;
      logic [7:0] back_red;
      logic [7:0] back_green;
      logic [7:0] back_blue;
   } color_type;

   localparam color_type COLOR_DEFAULT = '{
      fore_red: 8'hFF, fore_green: 8'hFF, fore_blue: 8'hFF,
      back_red: 8'h00, back_green: 8'h00, back_blue: 8'h00
   };

   typedef struct packed {
      logic        item_kind;
      logic [31:0] glyph_bytes;
      logic [2:0]  glyph_length;
      color_type   color;
      logic        final_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [7:0] clamp_comp(input logic [9:0] v);
      return (v > COMP_MAX) ? 8'hFF : v[7:0];
   endfunction

endpackage

@@ sv/atp_core.sv @@
// Byte parser: UTF-8 assembly, CSI number gathering and SGR colour state.
// Produces up to two result beats per accepted byte; uses atp_pkg.
module atp_core import atp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   input  logic       end_of_text,
   output push_type   push
);

   mode_type   mode_ff, mode_in;
   logic [23:0] partial_ff, partial_in;
   logic [1:0] owed_ff, owed_in;
   logic [1:0] held_ff, held_in;
   logic [9:0] acc_ff, acc_in;
   logic       digit_ff, digit_in;
   logic [2:0] wfill_ff, wfill_in;
   logic       wfore_ff, wfore_in;
   logic [7:0] wc0_ff, wc0_in;
   logic [7:0] wc1_ff, wc1_in;
   color_type  tent_ff, tent_in;
   color_type  comm_ff, comm_in;
   logic       line_ff, line_in;

   logic [13:0] acc_wide;
   logic [9:0]  acc_sat;
   logic        is_fb;
   color_type   en_tent;
   logic [2:0]  en_fill;
   logic        en_fore;
   logic [7:0]  en_c0;
   logic [7:0]  en_c1;
   logic [31:0] glyph_cat;
   logic        take_text;
   logic        main_valid;
   rsp_type     main_rsp;
   logic        part_valid;
   rsp_type     part_rsp;
   logic        eol_valid;
   rsp_type     eol_rsp;
   logic        line_end;

   assign acc_wide = 14'(acc_ff) * 14'd10 + 14'(text_byte[3:0]);
   assign acc_sat  = (acc_wide > 14'(NUM_MAX)) ? NUM_MAX : acc_wide[9:0];
   assign is_fb    = (acc_ff == SGR_FORE) || (acc_ff == SGR_BACK);
   assign glyph_cat = {8'h00, partial_ff} | (32'(text_byte) << {held_ff, 3'b000});

   // close the current number into the parameter window
   always_comb begin
      en_tent = tent_ff;
      en_fill = wfill_ff;
      en_fore = wfore_ff;
      en_c0   = wc0_ff;
      en_c1   = wc1_ff;
      if (digit_ff) begin
         unique case (wfill_ff)
            3'd0: begin
               if (acc_ff == SGR_RESET) begin
                  en_tent = COLOR_DEFAULT;
               end else if (is_fb) begin
                  en_fill = 3'd1;
                  en_fore = (acc_ff == SGR_FORE);
               end
            end
            3'd1: begin
               if (acc_ff == SGR_RGB) begin
                  en_fill = 3'd2;
               end else if (acc_ff == SGR_RESET) begin
                  en_tent = COLOR_DEFAULT;
                  en_fill = 3'd0;
               end else if (is_fb) begin
                  en_fill = 3'd1;
                  en_fore = (acc_ff == SGR_FORE);
               end else begin
                  en_fill = 3'd0;
               end
            end
            3'd2: begin
               en_c0   = clamp_comp(acc_ff);
               en_fill = 3'd3;
            end
            3'd3: begin
               en_c1   = clamp_comp(acc_ff);
               en_fill = 3'd4;
            end
            default: begin
               if (wfore_ff) begin
                  en_tent.fore_red   = wc0_ff;
                  en_tent.fore_green = wc1_ff;
                  en_tent.fore_blue  = clamp_comp(acc_ff);
               end else begin
                  en_tent.back_red   = wc0_ff;
                  en_tent.back_green = wc1_ff;
                  en_tent.back_blue  = clamp_comp(acc_ff);
               end
               en_fill = 3'd0;
            end
         endcase
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      partial_in = partial_ff;
      owed_in    = owed_ff;
      held_in    = held_ff;
      acc_in     = acc_ff;
      digit_in   = digit_ff;
      wfill_in   = wfill_ff;
      wfore_in   = wfore_ff;
      wc0_in     = wc0_ff;
      wc1_in     = wc1_ff;
      tent_in    = tent_ff;
      comm_in    = comm_ff;
      line_in    = line_ff;
      take_text  = 1'b0;
      main_valid = 1'b0;
      main_rsp   = '0;

      if (owed_ff != 2'd0) begin
         partial_in = glyph_cat[23:0];
         held_in    = held_ff + 2'd1;
         owed_in    = owed_ff - 2'd1;
         if (owed_ff == 2'd1) begin
            main_valid            = 1'b1;
            main_rsp.item_kind    = KIND_CHAR;
            main_rsp.glyph_bytes  = glyph_cat;
            main_rsp.glyph_length = {1'b0, held_ff} + 3'd1;
            main_rsp.color        = comm_ff;
            line_in    = 1'b1;
            partial_in = '0;
            held_in    = 2'd0;
         end
      end else begin
         unique case (mode_ff)
            MODE_CSI: begin
               priority if (text_byte >= CHAR_ZERO && text_byte <= CHAR_NINE) begin
                  acc_in   = acc_sat;
                  digit_in = 1'b1;
               end else if (text_byte == CHAR_SEMI) begin
                  tent_in  = en_tent;
                  wfill_in = en_fill;
                  wfore_in = en_fore;
                  wc0_in   = en_c0;
                  wc1_in   = en_c1;
                  acc_in   = '0;
                  digit_in = 1'b0;
               end else if (text_byte == CHAR_SGR) begin
                  if ((en_fill >= 3'd3 && en_c0 == 8'h00) ||
                      (en_fill == 3'd4 && en_c1 == 8'h00)) begin
                     tent_in = COLOR_DEFAULT;
                  end else begin
                     tent_in = en_tent;
                  end
                  comm_in  = tent_in;
                  acc_in   = '0;
                  digit_in = 1'b0;
                  wfill_in = '0;
                  mode_in  = MODE_NORMAL;
               end else if (text_byte == CHAR_RESET_MODE ||
                            text_byte == CHAR_SET_MODE) begin
                  tent_in  = comm_ff;
                  acc_in   = '0;
                  digit_in = 1'b0;
                  wfill_in = '0;
                  mode_in  = MODE_NORMAL;
               end else begin
               end
            end
            MODE_ESC: begin
               mode_in = MODE_NORMAL;
               if (text_byte == CHAR_LBRACKET) begin
                  mode_in  = MODE_CSI;
                  acc_in   = '0;
                  digit_in = 1'b0;
                  wfill_in = '0;
                  tent_in  = comm_ff;
               end else begin
                  take_text = 1'b1;
               end
            end
            default: begin
               mode_in   = MODE_NORMAL;
               take_text = 1'b1;
            end
         endcase

         if (take_text) begin
            priority if (text_byte == CHAR_ESC) begin
               mode_in = MODE_ESC;
            end else if (text_byte == CHAR_NEWLINE) begin
               if (line_ff) begin
                  main_valid         = 1'b1;
                  main_rsp.item_kind = KIND_EOL;
                  line_in            = 1'b0;
               end
            end else if (text_byte < CHAR_SPACE) begin
            end else if (text_byte < CHAR_ASCII_END) begin
               main_valid            = 1'b1;
               main_rsp.item_kind    = KIND_CHAR;
               main_rsp.glyph_bytes  = 32'(text_byte);
               main_rsp.glyph_length = 3'd1;
               main_rsp.color        = comm_ff;
               line_in               = 1'b1;
            end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
               owed_in    = 2'd1;
               partial_in = 24'(text_byte);
               held_in    = 2'd1;
            end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
               owed_in    = 2'd2;
               partial_in = 24'(text_byte);
               held_in    = 2'd1;
            end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
               owed_in    = 2'd3;
               partial_in = 24'(text_byte);
               held_in    = 2'd1;
            end else begin
            end
         end
      end

      // flush at end of text, then return to reset state
      part_valid            = end_of_text && (owed_in != 2'd0);
      part_rsp              = '0;
      part_rsp.item_kind    = KIND_CHAR;
      part_rsp.glyph_bytes  = {8'h00, partial_in};
      part_rsp.glyph_length = {1'b0, held_in};
      part_rsp.color        = comm_in;
      line_end              = line_in || part_valid;
      eol_valid             = end_of_text && line_end;
      eol_rsp               = '0;
      eol_rsp.item_kind     = KIND_EOL;

      if (end_of_text) begin
         mode_in    = MODE_NORMAL;
         partial_in = '0;
         owed_in    = '0;
         held_in    = '0;
         acc_in     = '0;
         digit_in   = 1'b0;
         wfill_in   = '0;
         wfore_in   = 1'b0;
         wc0_in     = '0;
         wc1_in     = '0;
         tent_in    = COLOR_DEFAULT;
         comm_in    = COLOR_DEFAULT;
         line_in    = 1'b0;
      end

      push.count  = 2'({1'b0, main_valid} + {1'b0, part_valid} + {1'b0, eol_valid});
      push.first  = main_valid ? main_rsp : (part_valid ? part_rsp : eol_rsp);
      push.second = eol_rsp;
      push.first.final_of_run  = (push.count == 2'd1);
      push.second.final_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         partial_ff <= '0;
         owed_ff    <= '0;
         held_ff    <= '0;
         acc_ff     <= '0;
         digit_ff   <= 1'b0;
         wfill_ff   <= '0;
         wfore_ff   <= 1'b0;
         wc0_ff     <= '0;
         wc1_ff     <= '0;
         tent_ff    <= COLOR_DEFAULT;
         comm_ff    <= COLOR_DEFAULT;
         line_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         partial_ff <= partial_in;
         owed_ff    <= owed_in;
         held_ff    <= held_in;
         acc_ff     <= acc_in;
         digit_ff   <= digit_in;
         wfill_ff   <= wfill_in;
         wfore_ff   <= wfore_in;
         wc0_ff     <= wc0_in;
         wc1_ff     <= wc1_in;
         tent_ff    <= tent_in;
         comm_ff    <= comm_in;
         line_ff    <= line_in;
      end
   end

   a_glyph_count: assert property (@(posedge clock) disable iff (reset)
      owed_ff != 2'd0 |-> held_ff != 2'd0 &&
         ({1'b0, owed_ff} + {1'b0, held_ff}) <= 3'd4)
      else $error("glyph byte counts out of range");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_text |=> mode_ff == MODE_NORMAL && !line_ff &&
         owed_ff == 2'd0 && wfill_ff == 3'd0)
      else $error("state not cleared after end of text");

   a_window_idle: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_CSI |-> wfill_ff == 3'd0 && !digit_ff)
      else $error("parameter window busy outside a sequence");

endmodule

@@ sv/atp_queue.sv @@
// Result queue: up to two beats in, one out, per cycle unless stalled.
// Uses atp_pkg for the result and push types.
module atp_queue import atp_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_en,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  head
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rsp_type        slot_ff [DEPTH];
   logic [AW-1:0]  rd_ff, rd_in;
   logic [AW-1:0]  wr_ff, wr_in;
   logic [AW-1:0]  wr_one;
   logic [AW-1:0]  wr_two;
   logic [CW-1:0]  count_ff, count_in;
   logic [1:0]     n;
   logic           pop;

   assign n      = push_en ? push.count : 2'd0;
   assign pop    = rsp_valid && !rsp_stall;
   assign wr_one = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign wr_two = (wr_one == AW'(DEPTH - 1)) ? '0 : wr_one + 1'b1;
   assign rd_in  = pop ? ((rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
   assign wr_in  = (n == 2'd0) ? wr_ff : ((n == 2'd1) ? wr_one : wr_two);
   assign count_in  = count_ff + CW'(n) - CW'(pop);
   assign room      = count_ff <= CW'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign head      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (n != 2'd0) begin
         slot_ff[wr_ff] <= push.first;
      end
      if (n == 2'd2) begin
         slot_ff[wr_one] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue overflow");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      n != 2'd0 |-> ({1'b0, count_ff} + (CW + 1)'(n)) <= (CW + 1)'(DEPTH))
      else $error("push without room");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      n != 2'd0 |=> rsp_valid)
      else $error("pushed beat not visible");

endmodule

@@ sv/ansi_truecolor_text_parser.sv @@
// Top level of the ANSI 24-bit colour text parser.
// Instantiates atp_core and atp_queue; uses atp_pkg.
// Takes one byte per clock unless req_stall; returns characters with colours and line breaks.
// A byte is taken whenever the result queue (DEPTH beats, default 4) has room for two beats.
// Result beats leave the registered queue one per clock while rsp_stall is low.
// Only end-of-text can cause two beats, so an unstalled stream runs at one byte per clock.
module ansi_truecolor_text_parser import atp_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [31:0] rsp_glyph_bytes,
   output logic [2:0]  rsp_glyph_length,
   output logic [7:0]  rsp_fore_red,
   output logic [7:0]  rsp_fore_green,
   output logic [7:0]  rsp_fore_blue,
   output logic [7:0]  rsp_back_red,
   output logic [7:0]  rsp_back_green,
   output logic [7:0]  rsp_back_blue,
   output logic        rsp_final_of_run
);

   logic     accept;
   logic     room;
   push_type push;
   rsp_type  head;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   atp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   atp_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_item_kind    = head.item_kind;
   assign rsp_glyph_bytes  = head.glyph_bytes;
   assign rsp_glyph_length = head.glyph_length;
   assign rsp_fore_red     = head.color.fore_red;
   assign rsp_fore_green   = head.color.fore_green;
   assign rsp_fore_blue    = head.color.fore_blue;
   assign rsp_back_red     = head.color.back_red;
   assign rsp_back_green   = head.color.back_green;
   assign rsp_back_blue    = head.color.back_blue;
   assign rsp_final_of_run = head.final_of_run;

endmodule
